// ----- hw/rtl/lrbp_pkg.sv -----
// lrbp_pkg: shared types, codes and constants of the link retry backoff policy
// no dependencies; used by the interfaces, the backoff unit and the top level
`default_nettype none

package lrbp_pkg;

  localparam int ACTION_W   = 3;
  localparam int TIME_W     = 63;
  localparam int MS_W       = 32;
  localparam int COUNT_W    = 4;
  localparam int INDEX_W    = 3;
  localparam int EXP_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int DECISION_W = 2;

  // largest number of networks the walk accepts
  localparam logic [COUNT_W-1:0] MAX_NETWORKS = 4'd8;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [EXP_W-1:0]  EXP_MAX  = {EXP_W{1'b1}};

  localparam logic [MS_W-1:0] RESET_RETRY_BASE_MS      = 32'd1000;
  localparam logic [MS_W-1:0] RESET_RETRY_CAP_MS       = 32'd60000;
  localparam logic [MS_W-1:0] RESET_ATTEMPT_TIMEOUT_MS = 32'd15000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK         = 3'd0,
    ACT_CONNECTED    = 3'd1,
    ACT_AUTH_FAILED  = 3'd2,
    ACT_NO_AP        = 3'd3,
    ACT_DISCONNECTED = 3'd4
  } action_t;

  typedef enum logic [DECISION_W-1:0] {
    DEC_NONE    = 2'd0,
    DEC_CONNECT = 2'd1,
    DEC_WAIT    = 2'd2
  } decision_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RETRY_BASE_MS      = 3'd0,
    REG_RETRY_CAP_MS       = 3'd1,
    REG_ATTEMPT_TIMEOUT_MS = 3'd2,
    REG_NET_TOTAL          = 3'd3,
    REG_CFG_EPOCH          = 3'd4,
    REG_CONFIG_VALID       = 3'd5
  } cfg_reg_t;

  // settings the backoff unit needs
  typedef struct packed {
    logic [MS_W-1:0] base_ms;
    logic [MS_W-1:0] cap_ms;
  } backoff_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lrbp_if.sv -----
// lrbp_if: valid/ready channels for link events and policy decisions
// depends on lrbp_pkg for field widths
`default_nettype none

interface lrbp_event_if;
  logic                          valid;
  logic                          ready;
  logic [lrbp_pkg::ACTION_W-1:0] action;
  logic [lrbp_pkg::TIME_W-1:0]   now_time;

  modport source (output valid, output action, output now_time, input ready);
  modport sink   (input valid, input action, input now_time, output ready);
endinterface

interface lrbp_result_if;
  logic                            valid;
  logic                            ready;
  logic [lrbp_pkg::DECISION_W-1:0] decision;
  logic [lrbp_pkg::INDEX_W-1:0]    target_index;
  logic                            link_up;
  logic                            retry_pending;
  logic [lrbp_pkg::TIME_W-1:0]     retry_deadline;

  modport source (output valid, output decision, output target_index, output link_up,
                  output retry_pending, output retry_deadline, input ready);
  modport sink   (input valid, input decision, input target_index, input link_up,
                  input retry_pending, input retry_deadline, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lrbp_backoff.sv -----
// lrbp_backoff: retry delay for a given backoff exponent, capped with early cap
// depends on lrbp_pkg
`default_nettype none

module lrbp_backoff (
  input  wire lrbp_pkg::backoff_cfg_t       cfg,
  input  wire [lrbp_pkg::EXP_W-1:0]         exponent,
  output logic [lrbp_pkg::MS_W-1:0]         delay
);

  localparam int WIDE_W = 2 * lrbp_pkg::MS_W;
  localparam logic [lrbp_pkg::EXP_W-1:0] SHIFT_LIMIT = 8'd32;

  logic [lrbp_pkg::MS_W-1:0]  half_cap;
  logic [lrbp_pkg::EXP_W-1:0] exp_less;
  logic [5:0]                 probe_shift;
  logic [WIDE_W-1:0]          base_wide;
  logic [WIDE_W-1:0]          probe;
  logic [WIDE_W-1:0]          scaled;
  logic                       early_cap;

  assign half_cap  = cfg.cap_ms >> 1;
  assign base_wide = {{lrbp_pkg::MS_W{1'b0}}, cfg.base_ms};
  assign exp_less  = exponent - 8'd1;

  // doubling is monotone, so the last step before the exponent decides the early cap
  assign probe_shift = (exp_less > SHIFT_LIMIT) ? 6'd32 : exp_less[5:0];
  assign probe       = base_wide << probe_shift;
  assign early_cap   = (exponent != '0) &&
                       (probe >= {{lrbp_pkg::MS_W{1'b0}}, half_cap});

  // past 32 steps only a zero base stays uncapped
  assign scaled = (exponent > SHIFT_LIMIT) ? '0 : (base_wide << exponent[5:0]);

  always_comb begin
    if (early_cap) begin
      delay = cfg.cap_ms;
    end else if (scaled < {{lrbp_pkg::MS_W{1'b0}}, cfg.cap_ms}) begin
      delay = scaled[lrbp_pkg::MS_W-1:0];
    end else begin
      delay = cfg.cap_ms;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/link_retry_backoff_policy.sv -----
// link_retry_backoff_policy: top level of the reconnect policy
// depends on lrbp_pkg, lrbp_if (event and result channels) and lrbp_backoff
`default_nettype none

// Reconnect policy for a station link. Each event beat (tick, connected, auth
// failed, no access point, disconnected, with a millisecond timestamp) gives
// exactly one result beat: no change, connect to target_index, or wait for a
// retry. Failures and attempt timeouts walk through the configured networks in
// order; when the list is used up a retry deadline is armed at now plus the
// backoff delay (base doubled per exponent step, capped, and forced to the cap
// once the running delay reaches half of it), saturated at the largest time.
// A new configuration epoch or network total restarts the walk at network 0.
// Throughput is one event per clock while results drain; an event is taken into
// the input register at its accepting edge; its result beat is registered into
// the result register when it is free, raising res.valid. A result held back by
// res.ready stalls the input only once the input register is full too. The
// delay for the current exponent sits in a register refreshed every cycle by
// the backoff unit, so the decision pass only has the deadline add and the
// time compares. Configuration is written through cfg_write/cfg_index/cfg_data
// and takes effect for events taken at or after the write edge.

module link_retry_backoff_policy (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_write,
  input  wire [lrbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [lrbp_pkg::MS_W-1:0]         cfg_data,
  lrbp_event_if.sink                       evt,
  lrbp_result_if.source                    res
);

  // configuration registers
  logic [lrbp_pkg::MS_W-1:0]    retry_base_ms, retry_base_ms_next;
  logic [lrbp_pkg::MS_W-1:0]    retry_cap_ms, retry_cap_ms_next;
  logic [lrbp_pkg::MS_W-1:0]    attempt_timeout_ms;
  logic [lrbp_pkg::COUNT_W-1:0] net_total;
  logic [lrbp_pkg::MS_W-1:0]    cfg_epoch;
  logic                         config_valid;

  // policy state
  logic [lrbp_pkg::MS_W-1:0]    seen_generation, seen_generation_next;
  logic [lrbp_pkg::COUNT_W-1:0] seen_count, seen_count_next;
  logic [lrbp_pkg::INDEX_W-1:0] current_index, current_index_next;
  logic [lrbp_pkg::EXP_W-1:0]   backoff_exponent, backoff_exponent_next;
  logic [lrbp_pkg::EXP_W-1:0]   exponent_fed;
  logic [lrbp_pkg::TIME_W-1:0]  attempt_start, attempt_start_next;
  logic                         attempt_armed, attempt_armed_next;
  logic [lrbp_pkg::TIME_W-1:0]  retry_time, retry_time_next;
  logic                         retry_armed, retry_armed_next;
  logic                         connected_flag, connected_flag_next;

  // delay for the current exponent
  logic [lrbp_pkg::MS_W-1:0]    retry_delay;
  logic [lrbp_pkg::MS_W-1:0]    delay_fed;
  lrbp_pkg::backoff_cfg_t       backoff_cfg;

  // input register
  logic                         in_valid;
  logic [lrbp_pkg::ACTION_W-1:0] in_action;
  logic [lrbp_pkg::TIME_W-1:0]  in_now;

  // result register
  logic                         out_valid;
  lrbp_pkg::decision_t          decision, decision_next;

  logic                         advance;
  logic                         process;

  // decision pass helpers
  logic [lrbp_pkg::TIME_W:0]    deadline_sum;
  logic [lrbp_pkg::TIME_W-1:0]  deadline_sat;
  logic [lrbp_pkg::TIME_W:0]    elapsed;
  logic                         timed_out;
  logic                         retry_due;
  logic                         cfg_usable;
  logic                         cfg_changed;
  logic [lrbp_pkg::COUNT_W-1:0] index_plus;
  logic                         do_advance;
  logic                         do_schedule;

  // handshake: result register drains or is empty, input register moves on
  assign advance   = !out_valid || res.ready;
  assign process   = in_valid && advance;
  assign evt.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (evt.ready) begin
      in_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      in_action <= evt.action;
      in_now    <= evt.now_time;
    end
  end

  // configuration; base and cap next values also feed the delay refresh
  always_comb begin
    retry_base_ms_next = retry_base_ms;
    retry_cap_ms_next  = retry_cap_ms;
    if (rst) begin
      retry_base_ms_next = lrbp_pkg::RESET_RETRY_BASE_MS;
      retry_cap_ms_next  = lrbp_pkg::RESET_RETRY_CAP_MS;
    end else if (cfg_write) begin
      if (cfg_index == lrbp_pkg::REG_RETRY_BASE_MS) begin
        retry_base_ms_next = cfg_data;
      end
      if (cfg_index == lrbp_pkg::REG_RETRY_CAP_MS) begin
        retry_cap_ms_next = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    retry_base_ms <= retry_base_ms_next;
    retry_cap_ms  <= retry_cap_ms_next;
    if (rst) begin
      attempt_timeout_ms <= lrbp_pkg::RESET_ATTEMPT_TIMEOUT_MS;
      net_total          <= '0;
      cfg_epoch          <= '0;
      config_valid       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        lrbp_pkg::REG_ATTEMPT_TIMEOUT_MS: attempt_timeout_ms <= cfg_data;
        lrbp_pkg::REG_NET_TOTAL:          net_total <= cfg_data[lrbp_pkg::COUNT_W-1:0];
        lrbp_pkg::REG_CFG_EPOCH:          cfg_epoch <= cfg_data;
        lrbp_pkg::REG_CONFIG_VALID:       config_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shared arithmetic of the decision pass
  assign deadline_sum = {1'b0, in_now} +
                        {{(lrbp_pkg::TIME_W + 1 - lrbp_pkg::MS_W){1'b0}}, retry_delay};
  assign deadline_sat = deadline_sum[lrbp_pkg::TIME_W] ? lrbp_pkg::TIME_MAX
                                                       : deadline_sum[lrbp_pkg::TIME_W-1:0];
  // top bit is the borrow: time went backwards
  assign elapsed   = {1'b0, in_now} - {1'b0, attempt_start};
  assign timed_out = attempt_armed && !elapsed[lrbp_pkg::TIME_W] &&
                     (elapsed[lrbp_pkg::TIME_W-1:0] >=
                      {{(lrbp_pkg::TIME_W - lrbp_pkg::MS_W){1'b0}}, attempt_timeout_ms});
  assign retry_due = in_now >= retry_time;

  assign cfg_usable  = config_valid && (net_total != '0) &&
                       (net_total <= lrbp_pkg::MAX_NETWORKS);
  assign cfg_changed = (seen_generation != cfg_epoch) ||
                       (seen_count != net_total);
  assign index_plus  = {1'b0, current_index} + 4'd1;

  always_comb begin
    seen_generation_next  = seen_generation;
    seen_count_next       = seen_count;
    current_index_next    = current_index;
    backoff_exponent_next = backoff_exponent;
    attempt_start_next    = attempt_start;
    attempt_armed_next    = attempt_armed;
    retry_time_next       = retry_time;
    retry_armed_next      = retry_armed;
    connected_flag_next   = connected_flag;
    decision_next         = lrbp_pkg::DEC_NONE;
    do_advance            = 1'b0;
    do_schedule           = 1'b0;

    if (!cfg_usable) begin
      decision_next = lrbp_pkg::DEC_NONE;
    end else if (cfg_changed) begin
      // new configuration restarts the walk, the event itself is dropped
      seen_generation_next  = cfg_epoch;
      seen_count_next       = net_total;
      current_index_next    = '0;
      backoff_exponent_next = '0;
      attempt_start_next    = in_now;
      attempt_armed_next    = 1'b1;
      retry_armed_next      = 1'b0;
      connected_flag_next   = 1'b0;
      decision_next         = lrbp_pkg::DEC_CONNECT;
    end else begin
      case (in_action)
        lrbp_pkg::ACT_CONNECTED: begin
          connected_flag_next   = 1'b1;
          backoff_exponent_next = '0;
          retry_armed_next      = 1'b0;
        end
        lrbp_pkg::ACT_AUTH_FAILED, lrbp_pkg::ACT_NO_AP: begin
          if (retry_armed) begin
            decision_next = lrbp_pkg::DEC_WAIT;
          end else begin
            do_advance = 1'b1;
          end
        end
        lrbp_pkg::ACT_DISCONNECTED: begin
          if (connected_flag) begin
            do_schedule = 1'b1;
          end
        end
        lrbp_pkg::ACT_TICK: begin
          if (connected_flag) begin
            decision_next = lrbp_pkg::DEC_NONE;
          end else if (retry_armed) begin
            if (retry_due) begin
              retry_armed_next   = 1'b0;
              attempt_start_next = in_now;
              attempt_armed_next = 1'b1;
              current_index_next = '0;
              decision_next      = lrbp_pkg::DEC_CONNECT;
            end
          end else if (timed_out) begin
            do_advance = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // move to the next network, or back off once the list is used up
    if (do_advance) begin
      if (index_plus < seen_count) begin
        current_index_next  = index_plus[lrbp_pkg::INDEX_W-1:0];
        connected_flag_next = 1'b0;
        attempt_start_next  = in_now;
        attempt_armed_next  = 1'b1;
        retry_armed_next    = 1'b0;
        decision_next       = lrbp_pkg::DEC_CONNECT;
      end else begin
        do_schedule = 1'b1;
      end
    end

    if (do_schedule) begin
      current_index_next  = '0;
      connected_flag_next = 1'b0;
      attempt_armed_next  = 1'b0;
      retry_armed_next    = 1'b1;
      retry_time_next     = deadline_sat;
      if ((retry_delay < retry_cap_ms) && (backoff_exponent != lrbp_pkg::EXP_MAX)) begin
        backoff_exponent_next = backoff_exponent + 8'd1;
      end
      decision_next = lrbp_pkg::DEC_WAIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_generation  <= '0;
      seen_count       <= '0;
      current_index    <= '0;
      backoff_exponent <= '0;
      attempt_start    <= '0;
      attempt_armed    <= 1'b0;
      retry_time       <= '0;
      retry_armed      <= 1'b0;
      connected_flag   <= 1'b0;
    end else if (process) begin
      seen_generation  <= seen_generation_next;
      seen_count       <= seen_count_next;
      current_index    <= current_index_next;
      backoff_exponent <= backoff_exponent_next;
      attempt_start    <= attempt_start_next;
      attempt_armed    <= attempt_armed_next;
      retry_time       <= retry_time_next;
      retry_armed      <= retry_armed_next;
      connected_flag   <= connected_flag_next;
    end
  end

  // delay register tracks the exponent the next event will see
  always_comb begin
    if (rst) begin
      exponent_fed = '0;
    end else if (process) begin
      exponent_fed = backoff_exponent_next;
    end else begin
      exponent_fed = backoff_exponent;
    end
  end

  assign backoff_cfg.base_ms = retry_base_ms_next;
  assign backoff_cfg.cap_ms  = retry_cap_ms_next;

  lrbp_backoff u_backoff (
    .cfg      (backoff_cfg),
    .exponent (exponent_fed),
    .delay    (delay_fed)
  );

  always_ff @(posedge clk) begin
    retry_delay <= delay_fed;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      decision           <= decision_next;
      res.target_index   <= current_index_next;
      res.link_up        <= connected_flag_next;
      res.retry_pending  <= retry_armed_next;
      res.retry_deadline <= retry_armed_next ? retry_time_next : '0;
    end
  end

  assign res.valid    = out_valid;
  assign res.decision = decision;

endmodule

`default_nettype wire
